### hdl/lamp_command_frame_builder_assert.svh
// assertion macros for the lamp command frame builder
// used by lamp_command_frame_builder.sv, no other dependencies
`ifndef LAMP_COMMAND_FRAME_BUILDER_ASSERT_SVH
`define LAMP_COMMAND_FRAME_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define LCFB_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcfb assertion failed");
`define LCFB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcfb assertion failed");
`else
`define LCFB_ASSERT_SAME(label, clk, rstn, ante, cons)
`define LCFB_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### hdl/lcfb_pkg.sv
// shared types and constants for the lamp command frame builder
// no dependencies
`default_nettype none

package lcfb_pkg;

    localparam int HEADER_LEN     = 6;
    localparam int PAYLOAD_FIELDS = 6;

    localparam logic [7:0] CHECK_SEED = 8'hAB;
    localparam logic [7:0] TERMINATOR = 8'h0D;

    localparam logic [7:0] FRAME_HEADER [0:HEADER_LEN-1] =
        '{8'hAA, 8'h0A, 8'hFC, 8'h3A, 8'h86, 8'h00};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_COMMAND,
        ST_PAYLOAD,
        ST_SEQ,
        ST_SUM,
        ST_TERM
    } state_t;

endpackage

`default_nettype wire

### hdl/lamp_command_frame_builder.sv
// lamp command frame builder: serializes one command request into framed bytes
// depends on lcfb_pkg and lamp_command_frame_builder_assert.svh
//
// Usage:
//   the s_ channel takes one request: two command bytes, six payload bytes
//   and a payload length (saturated to MAX_PAYLOAD). the m_ channel gives
//   the frame one byte per transfer: header AA 0A FC 3A 86 00, the command
//   bytes, the payload, the sequence byte, the checksum and 0D.
//   m_frame_end marks each terminator byte, m_last the final byte of the request.
//   the checksum is accumulated by one 8-bit adder as bytes go out, so a
//   frame goes out one byte per cycle while m_ready is high: 11 + length
//   bytes, 11 to 17. a request seen with the sequence counter at zero sends
//   the frame twice (sequence 0 then 1), 22 to 34 bytes. the first byte
//   reaches the output register after the request has moved the sequencer
//   into its header state; s_ready rises again at the edge that loads the
//   terminator byte of the request's last frame. a stall on m_ready holds
//   the output register and the sequencer in place. reset clears the
//   sequence counter and empties the output register.
`default_nettype none

`include "lamp_command_frame_builder_assert.svh"

module lamp_command_frame_builder #(
    parameter int MAX_PAYLOAD = 6
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_command_high,
    input  wire logic [7:0] s_command_low,
    input  wire logic [7:0] s_payload_0,
    input  wire logic [7:0] s_payload_1,
    input  wire logic [7:0] s_payload_2,
    input  wire logic [7:0] s_payload_3,
    input  wire logic [7:0] s_payload_4,
    input  wire logic [7:0] s_payload_5,
    input  wire logic [2:0] s_payload_length,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_frame_byte,
    output logic            m_frame_end,
    output logic            m_last
);

    localparam int CNT_W = ($clog2(MAX_PAYLOAD + 1) > 3) ? $clog2(MAX_PAYLOAD + 1) : 3;

    lcfb_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] len_reg;
    logic [7:0]       cmd_high_reg, cmd_low_reg;
    logic [7:0]       payload_reg [0:lcfb_pkg::PAYLOAD_FIELDS-1];
    logic [7:0]       seq_counter_reg;
    logic             dup_reg;
    logic [7:0]       sum_reg, sum_next;

    logic             m_valid_reg;
    logic [7:0]       m_frame_byte_reg;
    logic             m_frame_end_reg;
    logic             m_last_reg;

    logic             accept;
    logic             advance;
    logic [7:0]       byte_cur;
    logic             frame_end_cur;
    logic             last_cur;
    logic [CNT_W-1:0] len_in;

    assign s_ready = (state_reg == lcfb_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign advance = (state_reg != lcfb_pkg::ST_IDLE) && (!m_valid_reg || m_ready);

    assign len_in = (CNT_W'(s_payload_length) > CNT_W'(MAX_PAYLOAD)) ?
                    CNT_W'(MAX_PAYLOAD) : CNT_W'(s_payload_length);

    // next state of the byte sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (accept) begin
            state_next = lcfb_pkg::ST_HEADER;
            cnt_next   = '0;
        end else if (advance) begin
            case (state_reg)
                lcfb_pkg::ST_HEADER: begin
                    if (cnt_reg == CNT_W'(lcfb_pkg::HEADER_LEN - 1)) begin
                        state_next = lcfb_pkg::ST_COMMAND;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                lcfb_pkg::ST_COMMAND: begin
                    if (cnt_reg[0]) begin
                        state_next = (len_reg == '0) ? lcfb_pkg::ST_SEQ : lcfb_pkg::ST_PAYLOAD;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                lcfb_pkg::ST_PAYLOAD: begin
                    if (cnt_reg + 1'b1 == len_reg) begin
                        state_next = lcfb_pkg::ST_SEQ;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                lcfb_pkg::ST_SEQ:  state_next = lcfb_pkg::ST_SUM;
                lcfb_pkg::ST_SUM:  state_next = lcfb_pkg::ST_TERM;
                lcfb_pkg::ST_TERM: begin
                    state_next = dup_reg ? lcfb_pkg::ST_HEADER : lcfb_pkg::ST_IDLE;
                    cnt_next   = '0;
                end
                default: state_next = lcfb_pkg::ST_IDLE;
            endcase
        end
    end

    // byte selection for the current sequencer position
    always_comb begin
        byte_cur      = '0;
        frame_end_cur = 1'b0;
        last_cur      = 1'b0;
        case (state_reg)
            lcfb_pkg::ST_HEADER:  byte_cur = lcfb_pkg::FRAME_HEADER[cnt_reg[2:0]];
            lcfb_pkg::ST_COMMAND: byte_cur = cnt_reg[0] ? cmd_low_reg : cmd_high_reg;
            lcfb_pkg::ST_PAYLOAD: begin
                // positions past the input fields go out as zero
                if (cnt_reg < CNT_W'(lcfb_pkg::PAYLOAD_FIELDS)) begin
                    byte_cur = payload_reg[cnt_reg[2:0]];
                end
            end
            lcfb_pkg::ST_SEQ:  byte_cur = seq_counter_reg;
            lcfb_pkg::ST_SUM:  byte_cur = sum_reg;
            lcfb_pkg::ST_TERM: begin
                byte_cur      = lcfb_pkg::TERMINATOR;
                frame_end_cur = 1'b1;
                last_cur      = !dup_reg;
            end
            default: byte_cur = '0;
        endcase
    end

    // running checksum through the shared adder
    always_comb begin
        sum_next = sum_reg;
        if (accept) begin
            sum_next = lcfb_pkg::CHECK_SEED;
        end else if (advance) begin
            if (state_reg == lcfb_pkg::ST_TERM) begin
                sum_next = lcfb_pkg::CHECK_SEED;
            end else if (state_reg != lcfb_pkg::ST_SUM) begin
                sum_next = sum_reg + byte_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= lcfb_pkg::ST_IDLE;
            cnt_reg         <= '0;
            seq_counter_reg <= '0;
            dup_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (accept) begin
                dup_reg <= (seq_counter_reg == 8'd0);
            end else if (advance && state_reg == lcfb_pkg::ST_TERM) begin
                dup_reg         <= 1'b0;
                seq_counter_reg <= seq_counter_reg + 8'd1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
        if (accept) begin
            cmd_high_reg   <= s_command_high;
            cmd_low_reg    <= s_command_low;
            payload_reg[0] <= s_payload_0;
            payload_reg[1] <= s_payload_1;
            payload_reg[2] <= s_payload_2;
            payload_reg[3] <= s_payload_3;
            payload_reg[4] <= s_payload_4;
            payload_reg[5] <= s_payload_5;
            len_reg        <= len_in;
        end
        if (advance) begin
            m_frame_byte_reg <= byte_cur;
            m_frame_end_reg  <= frame_end_cur;
            m_last_reg       <= last_cur;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_frame_byte_reg;
    assign m_frame_end  = m_frame_end_reg;
    assign m_last       = m_last_reg;

    `LCFB_ASSERT_SAME(a_last_on_term, aclk, aresetn, m_valid && m_last, m_frame_end)
    `LCFB_ASSERT_SAME(a_term_byte, aclk, aresetn, m_valid && m_frame_end, m_frame_byte == lcfb_pkg::TERMINATOR)
    `LCFB_ASSERT_NEXT(a_dup_on_zero, aclk, aresetn, accept && seq_counter_reg == 8'd0, dup_reg)
    `LCFB_ASSERT_NEXT(a_seq_step, aclk, aresetn, advance && state_reg == lcfb_pkg::ST_TERM, seq_counter_reg == $past(seq_counter_reg) + 8'd1)

endmodule

`default_nettype wire

### test/tb.sv
// testbench for lamp_command_frame_builder: directed and random command requests
// predicts every frame byte and checks it on the m_ channel under random stalls
// depends on lcfb_pkg and the lamp_command_frame_builder rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAYLOAD  = 6;
    localparam int FRAME_MAX    = lcfb_pkg::HEADER_LEN + 2 + MAX_PAYLOAD + 3;
    localparam int STALL_LIMIT  = 2000;
    localparam int QUIET_TAIL   = 40;
    localparam int RANDOM_COUNT = 400;

    typedef struct packed {
        logic [7:0]      command_high;
        logic [7:0]      command_low;
        logic [5:0][7:0] payload;
        logic [2:0]      length;
        logic            wait_drain;
    } lamp_request_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       last;
    } frame_beat_t;

    logic       aclk             = 1'b0;
    logic       aresetn          = 1'b0;
    logic       s_valid          = 1'b0;
    logic       s_ready;
    logic [7:0] s_command_high   = 8'h00;
    logic [7:0] s_command_low    = 8'h00;
    logic [7:0] s_payload_0      = 8'h00;
    logic [7:0] s_payload_1      = 8'h00;
    logic [7:0] s_payload_2      = 8'h00;
    logic [7:0] s_payload_3      = 8'h00;
    logic [7:0] s_payload_4      = 8'h00;
    logic [7:0] s_payload_5      = 8'h00;
    logic [2:0] s_payload_length = 3'd0;
    logic       m_valid;
    logic       m_ready          = 1'b0;
    logic [7:0] m_frame_byte;
    logic       m_frame_end;
    logic       m_last;

    lamp_request_t request_q[$];
    frame_beat_t   frame_bytes_due[$];
    logic [7:0]    sequence_count = 8'd0;
    logic          drained        = 1'b1;
    logic          quiet_tail     = 1'b0;
    int            send_gap       = 0;
    int            take_stall     = 0;
    int            idle_cycles    = 0;
    int            error_count    = 0;

    lamp_command_frame_builder #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_command_high(s_command_high),
        .s_command_low(s_command_low),
        .s_payload_0(s_payload_0),
        .s_payload_1(s_payload_1),
        .s_payload_2(s_payload_2),
        .s_payload_3(s_payload_3),
        .s_payload_4(s_payload_4),
        .s_payload_5(s_payload_5),
        .s_payload_length(s_payload_length),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_frame_byte(m_frame_byte),
        .m_frame_end(m_frame_end),
        .m_last(m_last)
    );

    // serialize one frame into the expected byte stream
    function automatic void queue_frame(input lamp_request_t rq, input int unsigned len,
                                        input logic [7:0] seq, input logic closes_request);
        logic [7:0]  bytes [0:FRAME_MAX-1];
        logic [7:0]  sum;
        int unsigned n;
        frame_beat_t beat;
        n = 0;
        for (int k = 0; k < lcfb_pkg::HEADER_LEN; k++) begin
            bytes[n] = lcfb_pkg::FRAME_HEADER[k];
            n++;
        end
        bytes[n] = rq.command_high;
        n++;
        bytes[n] = rq.command_low;
        n++;
        for (int k = 0; k < len; k++) begin
            // positions past the input fields go out as zero
            bytes[n] = (k < lcfb_pkg::PAYLOAD_FIELDS) ? rq.payload[k] : 8'h00;
            n++;
        end
        bytes[n] = seq;
        n++;
        sum = lcfb_pkg::CHECK_SEED;
        for (int k = 0; k < n; k++) begin
            sum = sum + bytes[k];
        end
        bytes[n] = sum;
        n++;
        bytes[n] = lcfb_pkg::TERMINATOR;
        n++;
        for (int k = 0; k < n; k++) begin
            beat.frame_byte = bytes[k];
            beat.frame_end  = (k == n - 1);
            beat.last       = closes_request && (k == n - 1);
            frame_bytes_due.push_back(beat);
        end
    endfunction

    function automatic void predict_request(input lamp_request_t rq);
        int unsigned len;
        len = (rq.length > MAX_PAYLOAD) ? MAX_PAYLOAD : rq.length;
        if (sequence_count == 8'd0) begin
            // counter at zero: frame goes out twice, sequence 0 then 1
            queue_frame(rq, len, 8'd0, 1'b0);
            queue_frame(rq, len, 8'd1, 1'b1);
            sequence_count = 8'd2;
        end else begin
            queue_frame(rq, len, sequence_count, 1'b1);
            sequence_count = sequence_count + 8'd1;
        end
    endfunction

    function automatic void add_request(input logic [7:0] hi, input logic [7:0] lo,
                                        input logic [47:0] pay, input logic [2:0] len,
                                        input logic hold);
        lamp_request_t rq;
        rq.command_high = hi;
        rq.command_low  = lo;
        rq.payload      = pay;
        rq.length       = len;
        rq.wait_drain   = hold;
        request_q.push_back(rq);
    endfunction

    initial begin
        forever #5 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            quiet_tail <= (request_q.size() <= QUIET_TAIL);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (request_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (request_q[0].wait_drain && (!drained || s_valid)) begin
                    // hold off until every frame byte of earlier requests is out
                    s_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= $urandom_range(0, 5);
                end else begin
                    s_command_high   <= request_q[0].command_high;
                    s_command_low    <= request_q[0].command_low;
                    s_payload_0      <= request_q[0].payload[0];
                    s_payload_1      <= request_q[0].payload[1];
                    s_payload_2      <= request_q[0].payload[2];
                    s_payload_3      <= request_q[0].payload[3];
                    s_payload_4      <= request_q[0].payload[4];
                    s_payload_5      <= request_q[0].payload[5];
                    s_payload_length <= request_q[0].length;
                    s_valid          <= 1'b1;
                    void'(request_q.pop_front());
                end
            end
        end
    end

    // monitor: checks frame bytes, predicts accepted requests, drives m_ready
    always @(posedge aclk) begin
        frame_beat_t   due;
        lamp_request_t taken;
        if (!aresetn) begin
            m_ready        <= 1'b0;
            take_stall     <= 0;
            sequence_count = 8'd0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected frame byte: expected none, actual %02h",
                             $time, m_frame_byte);
                    error_count++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (m_frame_byte !== due.frame_byte) begin
                        $display("%0t: frame_byte expected %02h actual %02h",
                                 $time, due.frame_byte, m_frame_byte);
                        error_count++;
                    end
                    if (m_frame_end !== due.frame_end) begin
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, due.frame_end, m_frame_end);
                        error_count++;
                    end
                    if (m_last !== due.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, due.last, m_last);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                taken.command_high = s_command_high;
                taken.command_low  = s_command_low;
                taken.payload      = {s_payload_5, s_payload_4, s_payload_3,
                                      s_payload_2, s_payload_1, s_payload_0};
                taken.length       = s_payload_length;
                taken.wait_drain   = 1'b0;
                predict_request(taken);
            end
            if (take_stall > 0) begin
                take_stall <= take_stall - 1;
                m_ready    <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_ready    <= 1'b0;
                take_stall <= $urandom_range(0, 5);
            end else begin
                m_ready <= 1'b1;
            end
        end
        drained <= (frame_bytes_due.size() == 0);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("lamp_command_frame_builder: mismatch");
                $finish;
            end
        end
    end

    initial begin
        // extremes, every length, saturated length
        add_request(8'h00, 8'h00, 48'h000000000000, 3'd0, 1'b0);
        add_request(8'hFF, 8'hFF, 48'hFFFFFFFFFFFF, 3'd6, 1'b0);
        add_request(8'h55, 8'hAA, 48'h55AA55AA55AA, 3'd6, 1'b0);
        add_request(8'hAA, 8'h55, 48'hAA55AA55AA55, 3'd6, 1'b1);
        add_request(8'hFF, 8'h00, 48'hFFFFFFFFFFFF, 3'd7, 1'b0);
        add_request(8'h01, 8'h80, 48'h123456789ABC, 3'd1, 1'b0);
        add_request(8'h7F, 8'hFE, 48'hDEADBEEF0102, 3'd2, 1'b0);
        add_request(8'h0D, 8'hAA, 48'h0D0D0D0D0D0D, 3'd3, 1'b0);
        add_request(8'h80, 8'h01, 48'hFEDCBA987654, 3'd4, 1'b1);
        add_request(8'hC3, 8'h3C, 48'h0F0F0F0F0F0F, 3'd5, 1'b0);
        add_request(8'h00, 8'hFF, 48'hF0F0F0F0F0F0, 3'd7, 1'b0);
        add_request(8'hFF, 8'hFF, 48'hFFFFFFFFFFFF, 3'd0, 1'b0);
        add_request(8'h3A, 8'h86, 48'h00FF00FF00FF, 3'd6, 1'b0);
        add_request(8'h12, 8'h34, 48'hAAAAAAAAAAAA, 3'd1, 1'b0);
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            add_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        48'({$urandom, $urandom}), 3'($urandom_range(0, 7)),
                        ($urandom_range(0, 49) == 0));
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (request_q.size() != 0 || s_valid || !drained);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("lamp_command_frame_builder: match");
        end else begin
            $display("lamp_command_frame_builder: mismatch");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/lcfb_pkg.sv
hdl/lamp_command_frame_builder.sv
test/tb.sv
